>>> src/mktc_pkg.sv
// Package for the tile cache tag engine: sizes, key widths, sequencer
// states and the move-to-front command. No dependencies.
package mktc_pkg;

    // Cache geometry
    localparam int ENTRIES    = 16;
    localparam int COORD_BITS = 22;
    localparam int KEY_BITS   = 22;
    localparam int OUT_W      = 4;
    localparam int POS_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Stored tag width: input key bits that survive the coordinate mask
    localparam int TAG_W      = (COORD_BITS < KEY_BITS) ? COORD_BITS : KEY_BITS;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    // Move a recency position to the front
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] slot;
    } t_mtf_cmd;

    // Report a position or slot in the low bits of a result field
    function automatic logic [OUT_W-1:0] to_out(input logic [POS_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[OUT_W-1:0];
    endfunction

endpackage

>>> src/mru_keyed_tile_cache_tags.sv
// Tile cache tag engine: a lookup walks the recency list one entry per
// cycle through a single key comparator, then updates tags and recency.
// One lookup at a time: no new lookup is taken until the result of the last one
// is registered, and the update pass waits while the result register is held.
// Synchronous active-low reset: all entries invalid, recency list identity.
// Depends on mktc_pkg and mktc_recency.
module mru_keyed_tile_cache_tags
    import mktc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KEY_BITS-1:0] i_key_x,
    input  logic [KEY_BITS-1:0] i_key_z,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_hit,
    output logic [OUT_W-1:0]    o_slot,
    output logic [OUT_W-1:0]    o_search_depth
);

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos;
    logic             r_hit;
    logic [POS_W-1:0] r_cur_slot;
    logic [TAG_W-1:0] r_key_x, r_key_z;
    logic [TAG_W-1:0] r_tag_x [ENTRIES];
    logic [TAG_W-1:0] r_tag_z [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic             r_out_valid;
    logic             r_out_hit;
    logic [OUT_W-1:0] r_out_slot, r_out_depth;

    logic             w_in_accept;
    logic             w_out_free;
    logic [POS_W-1:0] w_slot;
    logic             w_match;
    logic             w_last;
    t_mtf_cmd         w_mtf;

    assign w_in_accept = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);

    // recency list
    mktc_recency u_recency (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_pos  (r_pos),
        .o_rd_slot (w_slot),
        .i_mtf     (w_mtf)
    );

    // shared comparator: one entry per cycle
    assign w_match = r_valid[w_slot] && (r_tag_x[w_slot] == r_key_x)
                     && (r_tag_z[w_slot] == r_key_z);
    assign w_last  = (r_pos == POS_W'(ENTRIES - 1));

    // update pass command
    always_comb begin
        w_mtf.en   = (r_state == S_UPDATE) && w_out_free;
        w_mtf.pos  = r_pos;
        w_mtf.slot = r_cur_slot;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (w_match || w_last) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_hit       <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_accept) begin
                r_pos <= '0;
            end else if (r_state == S_SEARCH && !w_match && !w_last) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (r_state == S_SEARCH) begin
                r_hit <= w_match;
            end
            if (w_mtf.en && !r_hit) begin
                r_valid[r_cur_slot] <= 1'b1;
            end
            if (w_mtf.en) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: key, current slot, tags, result
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_key_x <= i_key_x[TAG_W-1:0];
            r_key_z <= i_key_z[TAG_W-1:0];
        end
        if (r_state == S_SEARCH) begin
            r_cur_slot <= w_slot;
        end
        if (w_mtf.en && !r_hit) begin
            r_tag_x[r_cur_slot] <= r_key_x;
            r_tag_z[r_cur_slot] <= r_key_z;
        end
        if (w_mtf.en) begin
            r_out_hit   <= r_hit;
            r_out_slot  <= to_out(r_cur_slot);
            r_out_depth <= r_hit ? to_out(r_pos) : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_slot         = r_out_slot;
    assign o_search_depth = r_out_depth;

    // a new lookup starts its search at the front of the list
    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == S_SEARCH) && (r_pos == '0))
        else $error("search did not start at position zero");

    // a miss only reaches the update pass after scanning the whole list
    a_miss_full_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) && !r_hit |-> w_last)
        else $error("miss declared before the last position");

    // the reported slot is valid once the update pass is done
    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mtf.en |=> r_valid[$past(r_cur_slot)])
        else $error("reported slot not valid after update");

    // a miss reports depth zero
    a_miss_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> (o_search_depth == '0))
        else $error("miss with nonzero search depth");

endmodule

>>> src/mktc_recency.sv
// Recency list of the tile cache: slot at each position, most recent first.
// Depends on mktc_pkg.
module mktc_recency
    import mktc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [POS_W-1:0] i_rd_pos,
    output logic [POS_W-1:0] o_rd_slot,
    input  t_mtf_cmd         i_mtf
);

    logic [POS_W-1:0] r_order [ENTRIES];

    // single read port for the search
    assign o_rd_slot = r_order[i_rd_pos];

    // move-to-front: entries before pos shift back by one, slot goes first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ENTRIES; j++) begin
                r_order[j] <= POS_W'(j);
            end
        end else if (i_mtf.en) begin
            for (int j = 0; j < ENTRIES; j++) begin
                if (j == 0) begin
                    r_order[j] <= i_mtf.slot;
                end else if (POS_W'(j) <= i_mtf.pos) begin
                    r_order[j] <= r_order[j-1];
                end
            end
        end
    end

endmodule

>>> sim/tb_mru_keyed_tile_cache_tags.sv
// Testbench for mru_keyed_tile_cache_tags: directed and random key lookups with
// an in-bench recency/tag predictor and a result scoreboard.
// Depends on mktc_pkg and the RTL of the tag engine.
`timescale 1ns / 1ps

module tb_mru_keyed_tile_cache_tags
    import mktc_pkg::*;
;

    // Tag and recency predictor plus the queue of lookup results still owed
    class tile_tag_board;
        typedef struct packed {
            logic             hit;
            logic [OUT_W-1:0] slot;
            logic [OUT_W-1:0] depth;
        } t_lookup_res;

        logic [TAG_W-1:0] tag_x [ENTRIES];
        logic [TAG_W-1:0] tag_z [ENTRIES];
        logic             live  [ENTRIES];
        logic [POS_W-1:0] order [ENTRIES];
        t_lookup_res      expected_lookups[$];
        int               errors;
        int               checked;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                tag_x[i] = '0;
                tag_z[i] = '0;
                live[i]  = 1'b0;
                order[i] = POS_W'(i);
            end
            errors  = 0;
            checked = 0;
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        // Shift positions 0..pos-1 down one and put the slot from pos at the front
        function void bring_front(int pos);
            logic [POS_W-1:0] s;
            s = order[pos];
            for (int j = pos; j > 0; j--)
                order[j] = order[j-1];
            order[0] = s;
        endfunction

        // Accepted lookup: walk the recency list, update state, queue the result
        function void note_lookup(logic [KEY_BITS-1:0] kx, logic [KEY_BITS-1:0] kz);
            t_lookup_res      r;
            logic [POS_W-1:0] s;
            int               found;
            found = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                s = order[i];
                if (found < 0 && live[s] && tag_x[s] == kx[TAG_W-1:0]
                        && tag_z[s] == kz[TAG_W-1:0])
                    found = i;
            end
            if (found >= 0) begin
                s = order[found];
                bring_front(found);
                r.hit   = 1'b1;
                r.slot  = OUT_W'(s);
                r.depth = OUT_W'(found);
            end else begin
                // miss: least recent slot is replaced
                s = order[ENTRIES-1];
                bring_front(ENTRIES-1);
                tag_x[s] = kx[TAG_W-1:0];
                tag_z[s] = kz[TAG_W-1:0];
                live[s]  = 1'b1;
                r.hit    = 1'b0;
                r.slot   = OUT_W'(s);
                r.depth  = '0;
            end
            expected_lookups.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns MISMATCH: %s", $time, msg);
        endtask

        // Accepted result: compare with the oldest expectation
        task check_result(logic hit, logic [OUT_W-1:0] slot, logic [OUT_W-1:0] depth);
            t_lookup_res e;
            if (expected_lookups.size() == 0) begin
                report("result transaction with no lookup outstanding");
            end else begin
                e = expected_lookups.pop_front();
                if (hit !== e.hit)
                    report($sformatf("lookup %0d hit %b, expected %b", checked, hit, e.hit));
                if (slot !== e.slot)
                    report($sformatf("lookup %0d slot %0d, expected %0d",
                                     checked, slot, e.slot));
                if (depth !== e.depth)
                    report($sformatf("lookup %0d search_depth %0d, expected %0d",
                                     checked, depth, e.depth));
            end
            checked++;
        endtask
    endclass

    localparam logic [KEY_BITS-1:0] KEY_MIN  = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic [KEY_BITS-1:0] KEY_MAX  = {1'b0, {(KEY_BITS-1){1'b1}}};
    localparam logic [KEY_BITS-1:0] KEY_ONES = '1;
    localparam int                  POOL_MAX = 24;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [KEY_BITS-1:0] i_key_x;
    logic [KEY_BITS-1:0] i_key_z;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_hit;
    logic [OUT_W-1:0]    o_slot;
    logic [OUT_W-1:0]    o_search_depth;

    tile_tag_board board = new();

    bit running      = 1'b0;
    bit no_gap       = 1'b0;
    bit quiet_recv   = 1'b0;
    bit hold_request = 1'b0;
    int stall_left   = 0;

    logic [KEY_BITS-1:0] pool_x [POOL_MAX];
    logic [KEY_BITS-1:0] pool_z [POOL_MAX];
    int                  pool_n;

    mru_keyed_tile_cache_tags dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_key_x        (i_key_x),
        .i_key_z        (i_key_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_slot         (o_slot),
        .o_search_depth (o_search_depth)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: check accepted transactions, then pick next cycle's stall
    always @(posedge i_clk) begin
        if (running) begin
            if (o_out_valid && !i_out_stall)
                board.check_result(o_hit, o_slot, o_search_depth);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet_recv && $urandom_range(99) < 25) begin
                stall_left = idle_len() - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Offer one lookup, holding the payload until the transaction completes
    task automatic send_lookup(input logic [KEY_BITS-1:0] kx, input logic [KEY_BITS-1:0] kz);
        int gap;
        gap = (no_gap || $urandom_range(99) < 55) ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_key_x    <= kx;
        i_key_z    <= kz;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_lookup(kx, kz);
    endtask

    // Stop offering and wait for every owed result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Working set of keys: wide random or clustered around zero
    task automatic refill_pool(input bit clustered);
        for (int i = 0; i < POOL_MAX; i++) begin
            if (clustered) begin
                pool_x[i] = KEY_BITS'($urandom_range(0, 7) - 4);
                pool_z[i] = KEY_BITS'($urandom_range(0, 7) - 4);
            end else begin
                pool_x[i] = KEY_BITS'($urandom());
                pool_z[i] = KEY_BITS'($urandom());
            end
        end
    endtask

    initial begin
        int                  r;
        int                  k;
        logic [KEY_BITS-1:0] kx;
        logic [KEY_BITS-1:0] kz;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_key_x     <= '0;
        i_key_z     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        // Directed: invalid entries with zero tags never match the zero key
        send_lookup('0, '0);
        send_lookup('0, '0);
        send_lookup(KEY_MIN, KEY_MAX);
        send_lookup(KEY_MAX, KEY_MIN);
        send_lookup(KEY_ONES, KEY_ONES);
        // keys that differ in one coordinate only
        send_lookup('0, KEY_BITS'(1));
        send_lookup(KEY_BITS'(1), '0);
        // fill the rest of the cache, leaving the zero key least recent
        for (int i = 1; i <= 10; i++)
            send_lookup(KEY_BITS'(i * 4099), KEY_BITS'(-i));
        // hit at the deepest position, then evict and re-fetch an evicted key
        send_lookup('0, '0);
        send_lookup(KEY_BITS'(7), KEY_BITS'(7));
        send_lookup(KEY_MIN, KEY_MAX);
        send_lookup(KEY_BITS'(1), '0);
        send_lookup(KEY_BITS'(1), '0);

        // Random phases over a working set of keys, plus noise
        for (int p = 0; p < 13; p++) begin
            no_gap     = (p % 4 == 1) || (p == 3);
            quiet_recv = (p % 4 == 2);
            if (p == 6)
                wait_drained();
            if (p % 2 == 0)
                refill_pool(p % 4 == 2);
            pool_n = $urandom_range(4, POOL_MAX);
            if (p == 3)
                hold_request = 1'b1;
            for (int n = 0; n < 100; n++) begin
                r = $urandom_range(99);
                k = $urandom_range(pool_n - 1);
                kx = pool_x[k];
                kz = pool_z[k];
                if (r >= 90) begin
                    kx = KEY_BITS'($urandom());
                    kz = KEY_BITS'($urandom());
                end else if (r >= 85) begin
                    kx = kx ^ (KEY_BITS'(1) << $urandom_range(KEY_BITS - 1));
                end else if (r >= 80) begin
                    kz = kz ^ (KEY_BITS'(1) << $urandom_range(KEY_BITS - 1));
                end
                send_lookup(kx, kz);
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_mru_keyed_tile_cache_tags passed");
        end else begin
            $display("tb_mru_keyed_tile_cache_tags failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #15_000_000;
        $display("tb_mru_keyed_tile_cache_tags failed");
        $finish;
    end

endmodule
